FILE: sv/assert_macros.svh
// Assertion macros for the coordinate conversion block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CCRU_ASSERT_IMPLIES(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
    else $error(msg);
`define CCRU_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CCRU_ASSERT_IMPLIES(label, clk_s, rst_s, ante, cons, msg)
`define CCRU_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg)
`endif
`endif

FILE: sv/ccru_pkg.sv
package ccru_pkg;

  localparam int XY_W       = 48;
  localparam int GUARD      = 12;
  localparam int TAB_W      = 48;
  localparam int COMP_SPLIT = 23;
  localparam int COMP_SHIFT = GUARD + 9;
  localparam logic [31:0] GAIN_COMP = 32'd2608131496;

  localparam logic [2:0] CMD_CART_TO_POLAR = 3'd0;
  localparam logic [2:0] CMD_POLAR_TO_CART = 3'd1;
  localparam logic [2:0] CMD_ROTATE_CART   = 3'd2;
  localparam logic [2:0] CMD_ROTATE_POLAR  = 3'd3;
  localparam logic [2:0] CMD_SCALE_CART    = 3'd4;
  localparam logic [2:0] CMD_SCALE_POLAR   = 3'd5;

  typedef enum logic [1:0] {
    MODE_ROT,
    MODE_VEC,
    MODE_PASS
  } mode_t;

  typedef struct packed {
    logic  valid;
    mode_t mode;
    logic  flip;
  } ctrl_t;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    logic signed [31:0] turn_angle;
    logic signed [15:0] scale_factor;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] first_result;
    logic signed [31:0] second_result;
    logic               saturated;
  } out_item_t;

  // The arctangent table is built at elaboration with exact integer arithmetic.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] atan_inv_q60(input logic [63:0] n);
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] t;
    logic [63:0] k;
    term = udiv64(64'd1 << 60, n);
    sum  = '0;
    k    = '0;
    while (term != 64'd0) begin
      t = udiv64(term, (k << 1) + 64'd1);
      if (k[0]) begin
        sum = sum - t;
      end else begin
        sum = sum + t;
      end
      term = udiv64(term, n * n);
      k    = k + 64'd1;
    end
    return sum;
  endfunction

  function automatic logic [63:0] atan_pow2_q60(input int i);
    logic [63:0] sum;
    logic [63:0] t;
    int k;
    int e;
    sum = '0;
    k   = 0;
    while (i * (2 * k + 1) <= 60) begin
      e = 60 - i * (2 * k + 1);
      t = udiv64(64'd1 << e, 64'(2 * k + 1));
      if (k % 2 == 1) begin
        sum = sum - t;
      end else begin
        sum = sum + t;
      end
      k++;
    end
    return sum;
  endfunction

  function automatic logic [63:0] rad_to_turn48(input logic [63:0] rad,
                                                input logic [63:0] pi_q60);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = rad;
    for (int s = 0; s < 47; s++) begin
      r = r << 1;
      q = q << 1;
      if (r >= pi_q60) begin
        r    = r - pi_q60;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [TAB_W-1:0] atan_entry(input int i);
    logic [63:0] pi_q60;
    logic [63:0] turn;
    pi_q60 = 64'd16 * atan_inv_q60(64'd5) - 64'd4 * atan_inv_q60(64'd239);
    if (i == 0) begin
      turn = 64'd1 << 45;
    end else begin
      turn = rad_to_turn48(atan_pow2_q60(i), pi_q60);
    end
    return turn[TAB_W-1:0];
  endfunction

endpackage

FILE: sv/ccru_pre.sv
module ccru_pre #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  ccru_pkg::in_item_t                in_item,
  output ccru_pkg::ctrl_t                   ctrl_r,
  output logic signed [ccru_pkg::XY_W-1:0]  x_r,
  output logic signed [ccru_pkg::XY_W-1:0]  y_r,
  output logic signed [DATA_WIDTH+1:0]      z_r
);

  localparam int XY_W = ccru_pkg::XY_W;
  localparam int ZW   = DATA_WIDTH + 2;
  localparam int UP   = (DATA_WIDTH >= 32) ? DATA_WIDTH - 32 : 0;
  localparam int DN   = (DATA_WIDTH < 32) ? 32 - DATA_WIDTH : 0;

  logic signed [31:0]     a;
  logic signed [31:0]     b;
  logic signed [31:0]     w;
  logic signed [15:0]     s;
  logic signed [XY_W-1:0] xg;
  logic signed [XY_W-1:0] yg;
  logic signed [XY_W-1:0] prod_a;
  logic signed [XY_W-1:0] prod_b;
  logic signed [XY_W-1:0] y_src;
  logic signed [XY_W-1:0] x_rot;
  logic signed [XY_W-1:0] y_rot;
  logic [31:0]            ang;
  logic [31:0]            ang_pre;
  logic [31:0]            polar_sum;
  logic                   swap;
  logic signed [63:0]     ang_ext;
  logic signed [ZW-1:0]   z_rot;

  ccru_pkg::ctrl_t        ctrl_nxt;
  logic signed [XY_W-1:0] x_nxt;
  logic signed [XY_W-1:0] y_nxt;
  logic signed [ZW-1:0]   z_nxt;

  assign a = in_item.first_value;
  assign b = in_item.second_value;
  assign w = in_item.turn_angle;
  assign s = in_item.scale_factor;

  assign xg = {{(XY_W - 32){a[31]}}, a} << ccru_pkg::GUARD;
  assign yg = {{(XY_W - 32){b[31]}}, b} << ccru_pkg::GUARD;

  assign prod_a = XY_W'(a) * XY_W'(s);
  assign prod_b = XY_W'(b) * XY_W'(s);

  assign polar_sum = b + w;

  // Angles in the left half-plane are folded by a half turn.
  assign ang     = (in_item.command == ccru_pkg::CMD_POLAR_TO_CART) ? b : w;
  assign swap    = ang[31] ^ ang[30];
  assign ang_pre = {ang[31] ^ swap, ang[30:0]};
  assign ang_ext = {{32{ang_pre[31]}}, ang_pre};
  assign z_rot   = ZW'((ang_ext <<< UP) >>> DN);

  assign y_src = (in_item.command == ccru_pkg::CMD_POLAR_TO_CART) ? '0 : yg;
  assign x_rot = swap ? -xg : xg;
  assign y_rot = swap ? -y_src : y_src;

  always_comb begin
    ctrl_nxt.valid = in_valid;
    ctrl_nxt.mode  = ccru_pkg::MODE_PASS;
    ctrl_nxt.flip  = 1'b0;
    x_nxt          = {{(XY_W - 32){a[31]}}, a};
    y_nxt          = {{(XY_W - 32){b[31]}}, b};
    z_nxt          = '0;
    case (in_item.command)
      ccru_pkg::CMD_CART_TO_POLAR: begin
        ctrl_nxt.mode = ccru_pkg::MODE_VEC;
        ctrl_nxt.flip = a[31];
        x_nxt         = a[31] ? -xg : xg;
        y_nxt         = a[31] ? -yg : yg;
      end
      ccru_pkg::CMD_POLAR_TO_CART, ccru_pkg::CMD_ROTATE_CART: begin
        ctrl_nxt.mode = ccru_pkg::MODE_ROT;
        x_nxt         = x_rot;
        y_nxt         = y_rot;
        z_nxt         = z_rot;
      end
      ccru_pkg::CMD_ROTATE_POLAR: begin
        y_nxt = {{(XY_W - 32){polar_sum[31]}}, polar_sum};
      end
      ccru_pkg::CMD_SCALE_CART: begin
        x_nxt = prod_a;
        y_nxt = prod_b;
      end
      ccru_pkg::CMD_SCALE_POLAR: begin
        x_nxt = prod_a;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

endmodule

FILE: sv/ccru_stage.sv
module ccru_stage #(
  parameter int DATA_WIDTH = 32,
  parameter int STAGE      = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ccru_pkg::ctrl_t                   ctrl_i,
  input  logic signed [ccru_pkg::XY_W-1:0]  x_i,
  input  logic signed [ccru_pkg::XY_W-1:0]  y_i,
  input  logic signed [DATA_WIDTH+1:0]      z_i,
  output ccru_pkg::ctrl_t                   ctrl_r,
  output logic signed [ccru_pkg::XY_W-1:0]  x_r,
  output logic signed [ccru_pkg::XY_W-1:0]  y_r,
  output logic signed [DATA_WIDTH+1:0]      z_r
);

  localparam int XY_W = ccru_pkg::XY_W;
  localparam int ZW   = DATA_WIDTH + 2;
  localparam logic [ccru_pkg::TAB_W-1:0] TAB_FULL = ccru_pkg::atan_entry(STAGE);
  localparam logic signed [ZW-1:0] TAB =
    ZW'(TAB_FULL >> (ccru_pkg::TAB_W - DATA_WIDTH));

  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic                   pos;
  logic signed [XY_W-1:0] x_nxt;
  logic signed [XY_W-1:0] y_nxt;
  logic signed [ZW-1:0]   z_nxt;

  assign xs  = x_i >>> STAGE;
  assign ys  = y_i >>> STAGE;
  assign pos = (ctrl_i.mode == ccru_pkg::MODE_ROT) ? ~z_i[ZW-1] : y_i[XY_W-1];

  always_comb begin
    x_nxt = x_i;
    y_nxt = y_i;
    z_nxt = z_i;
    if (ctrl_i.mode != ccru_pkg::MODE_PASS) begin
      if (pos) begin
        x_nxt = x_i - ys;
        y_nxt = y_i + xs;
        z_nxt = z_i - TAB;
      end else begin
        x_nxt = x_i + ys;
        y_nxt = y_i - xs;
        z_nxt = z_i + TAB;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl_i;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

endmodule

FILE: sv/ccru_post.sv
module ccru_post #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ccru_pkg::ctrl_t                   ctrl_i,
  input  logic signed [ccru_pkg::XY_W-1:0]  x_i,
  input  logic signed [ccru_pkg::XY_W-1:0]  y_i,
  input  logic signed [DATA_WIDTH+1:0]      z_i,
  output logic                              valid_r,
  output ccru_pkg::out_item_t               item_r
);

  localparam int XY_W  = ccru_pkg::XY_W;
  localparam int ZW    = DATA_WIDTH + 2;
  localparam int UP    = (DATA_WIDTH >= 32) ? DATA_WIDTH - 32 : 0;
  localparam int DN    = (DATA_WIDTH < 32) ? 32 - DATA_WIDTH : 0;
  localparam int SPLIT = ccru_pkg::COMP_SPLIT;
  localparam int HI_W  = XY_W - SPLIT;
  localparam int PH_W  = HI_W + 32;
  localparam int PL_W  = SPLIT + 32;
  localparam int PS_W  = PH_W + 1;
  localparam logic signed [63:0] ANG_RND = (64'sd1 <<< UP) >>> 1;
  localparam logic [PS_W-1:0] CMP_RND = PS_W'(1) << (ccru_pkg::COMP_SHIFT - 1);

  function automatic logic [32:0] sat32(input logic signed [XY_W:0] v);
    logic ovf;
    ovf = (v[XY_W:31] != {(XY_W - 30){1'b0}}) && (v[XY_W:31] != {(XY_W - 30){1'b1}});
    if (ovf) begin
      return {1'b1, v[XY_W] ? 32'h8000_0000 : 32'h7FFF_FFFF};
    end
    return {1'b0, v[31:0]};
  endfunction

  // Magnitude, sign and output angle.
  ccru_pkg::ctrl_t  c1_r;
  logic             sx1_r;
  logic             sy1_r;
  logic [XY_W-1:0]  mx1_r;
  logic [XY_W-1:0]  my1_r;
  logic [31:0]      ang1_r;
  logic [XY_W-1:0]  mx1_nxt;
  logic [XY_W-1:0]  my1_nxt;
  logic signed [63:0] z_ext;
  logic signed [63:0] ang_v;
  logic [31:0]      ang1_nxt;

  // Gain products.
  ccru_pkg::ctrl_t  c2_r;
  logic             sx2_r;
  logic             sy2_r;
  logic [31:0]      ang2_r;
  logic [PH_W-1:0]  phx2_r;
  logic [PH_W-1:0]  phy2_r;
  logic [31:0]      plx2_r;
  logic [31:0]      ply2_r;
  logic             pass1;
  logic [PH_W-1:0]  mul_hx;
  logic [PH_W-1:0]  mul_hy;
  logic [PL_W-1:0]  mul_lx;
  logic [PL_W-1:0]  mul_ly;
  logic [PH_W-1:0]  phx2_nxt;
  logic [PH_W-1:0]  phy2_nxt;
  logic [31:0]      plx2_nxt;
  logic [31:0]      ply2_nxt;

  // Rounded magnitudes.
  ccru_pkg::ctrl_t  c3_r;
  logic             sx3_r;
  logic             sy3_r;
  logic [31:0]      ang3_r;
  logic [XY_W-1:0]  rx3_r;
  logic [XY_W-1:0]  ry3_r;
  logic             pass2;
  logic [PS_W-1:0]  sum_x;
  logic [PS_W-1:0]  sum_y;
  logic [XY_W-1:0]  rx3_nxt;
  logic [XY_W-1:0]  ry3_nxt;

  // Sign restore and clamp.
  logic signed [XY_W:0] vx;
  logic signed [XY_W:0] vy;
  logic [32:0]          satx;
  logic [32:0]          saty;
  logic                 vec3;
  ccru_pkg::out_item_t  item_nxt;

  assign mx1_nxt  = x_i[XY_W-1] ? XY_W'(-x_i) : XY_W'(x_i);
  assign my1_nxt  = y_i[XY_W-1] ? XY_W'(-y_i) : XY_W'(y_i);
  assign z_ext    = {{(64 - ZW){z_i[ZW-1]}}, z_i};
  assign ang_v    = ((z_ext + ANG_RND) >>> UP) <<< DN;
  assign ang1_nxt = ang_v[31:0] ^ {ctrl_i.flip, 31'd0};

  always_ff @(posedge clk) begin
    sx1_r  <= x_i[XY_W-1];
    sy1_r  <= y_i[XY_W-1];
    mx1_r  <= mx1_nxt;
    my1_r  <= my1_nxt;
    ang1_r <= ang1_nxt;
  end

  assign pass1  = (c1_r.mode == ccru_pkg::MODE_PASS);
  assign mul_hx = PH_W'(mx1_r[XY_W-1:SPLIT]) * PH_W'(ccru_pkg::GAIN_COMP);
  assign mul_hy = PH_W'(my1_r[XY_W-1:SPLIT]) * PH_W'(ccru_pkg::GAIN_COMP);
  assign mul_lx = PL_W'(mx1_r[SPLIT-1:0]) * PL_W'(ccru_pkg::GAIN_COMP);
  assign mul_ly = PL_W'(my1_r[SPLIT-1:0]) * PL_W'(ccru_pkg::GAIN_COMP);

  assign phx2_nxt = pass1 ? PH_W'(mx1_r) : mul_hx;
  assign phy2_nxt = pass1 ? PH_W'(my1_r) : mul_hy;
  assign plx2_nxt = pass1 ? '0 : 32'(mul_lx >> SPLIT);
  assign ply2_nxt = pass1 ? '0 : 32'(mul_ly >> SPLIT);

  always_ff @(posedge clk) begin
    sx2_r  <= sx1_r;
    sy2_r  <= sy1_r;
    ang2_r <= ang1_r;
    phx2_r <= phx2_nxt;
    phy2_r <= phy2_nxt;
    plx2_r <= plx2_nxt;
    ply2_r <= ply2_nxt;
  end

  assign pass2   = (c2_r.mode == ccru_pkg::MODE_PASS);
  assign sum_x   = PS_W'(phx2_r) + PS_W'(plx2_r) + CMP_RND;
  assign sum_y   = PS_W'(phy2_r) + PS_W'(ply2_r) + CMP_RND;
  assign rx3_nxt = pass2 ? phx2_r[XY_W-1:0] : XY_W'(sum_x >> ccru_pkg::COMP_SHIFT);
  assign ry3_nxt = pass2 ? phy2_r[XY_W-1:0] : XY_W'(sum_y >> ccru_pkg::COMP_SHIFT);

  always_ff @(posedge clk) begin
    sx3_r  <= sx2_r;
    sy3_r  <= sy2_r;
    ang3_r <= ang2_r;
    rx3_r  <= rx3_nxt;
    ry3_r  <= ry3_nxt;
  end

  assign vx   = sx3_r ? -$signed({1'b0, rx3_r}) : $signed({1'b0, rx3_r});
  assign vy   = sy3_r ? -$signed({1'b0, ry3_r}) : $signed({1'b0, ry3_r});
  assign satx = sat32(vx);
  assign saty = sat32(vy);
  assign vec3 = (c3_r.mode == ccru_pkg::MODE_VEC);

  always_comb begin
    item_nxt.first_result  = satx[31:0];
    item_nxt.second_result = vec3 ? ang3_r : saty[31:0];
    item_nxt.saturated     = satx[32] | (saty[32] & ~vec3);
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r    <= '0;
      c2_r    <= '0;
      c3_r    <= '0;
      valid_r <= 1'b0;
    end else begin
      c1_r    <= ctrl_i;
      c2_r    <= c1_r;
      c3_r    <= c2_r;
      valid_r <= c3_r.valid;
    end
  end

endmodule

FILE: sv/coordinate_convert_rotate_unit_core.sv
// Pipelined CORDIC unit for polar/Cartesian conversion, rotation and scaling. It takes one
// item in every clock cycle: start is accepted whenever busy is low, and busy is high only
// while reset is applied. Each result passes through one input stage, one register stage per
// micro-rotation and four stages for gain compensation, rounding and clamping, leaves in
// item order, and is shown on out_item for a single cycle with out_valid high. The receiver
// cannot hold results off and must take every strobe. Cartesian values and radii are signed
// Q16.16; angles are 32-bit binary angles.
`include "assert_macros.svh"

module coordinate_convert_rotate_unit_core #(
  parameter int DATA_WIDTH = 32,
  parameter int ITERATIONS = 30
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  ccru_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output ccru_pkg::out_item_t  out_item
);

  localparam int XY_W = ccru_pkg::XY_W;
  localparam int ZW   = DATA_WIDTH + 2;
  localparam int LAT  = ITERATIONS + 5;

  logic                   accept;
  ccru_pkg::ctrl_t        pipe_ctrl [ITERATIONS+1];
  logic signed [XY_W-1:0] pipe_x    [ITERATIONS+1];
  logic signed [XY_W-1:0] pipe_y    [ITERATIONS+1];
  logic signed [ZW-1:0]   pipe_z    [ITERATIONS+1];

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  ccru_pre #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_pre (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(accept),
    .in_item (in_item),
    .ctrl_r  (pipe_ctrl[0]),
    .x_r     (pipe_x[0]),
    .y_r     (pipe_y[0]),
    .z_r     (pipe_z[0])
  );

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_stage
    ccru_stage #(
      .DATA_WIDTH(DATA_WIDTH),
      .STAGE     (i)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl_i(pipe_ctrl[i]),
      .x_i   (pipe_x[i]),
      .y_i   (pipe_y[i]),
      .z_i   (pipe_z[i]),
      .ctrl_r(pipe_ctrl[i+1]),
      .x_r   (pipe_x[i+1]),
      .y_r   (pipe_y[i+1]),
      .z_r   (pipe_z[i+1])
    );
  end

  ccru_post #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_post (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl_i (pipe_ctrl[ITERATIONS]),
    .x_i    (pipe_x[ITERATIONS]),
    .y_i    (pipe_y[ITERATIONS]),
    .z_i    (pipe_z[ITERATIONS]),
    .valid_r(out_valid),
    .item_r (out_item)
  );

  `CCRU_ASSERT_IMPLIES(a_result_follows_item, clk, rst_n, accept, ##LAT out_valid, "item produced no result")
  `CCRU_ASSERT_IMPLIES(a_no_spurious_result, clk, rst_n, !accept, ##LAT !out_valid, "result without an item")
  `CCRU_ASSERT_IMPLIES(a_polar_rotate_radius, clk, rst_n, accept && (in_item.command == ccru_pkg::CMD_ROTATE_POLAR), ##LAT (!out_item.saturated && (out_item.first_result == $past(in_item.first_value, LAT))), "polar rotation changed the radius")
  `CCRU_ASSERT_IMPLIES(a_radius_not_negative, clk, rst_n, accept && (in_item.command == ccru_pkg::CMD_CART_TO_POLAR), ##LAT !out_item.first_result[31], "negative radius from conversion")

endmodule
